FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Clocked next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/rars_pkg.sv
// Package with the shared types and codes of the range add / range sum block.
package rars_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_SUM   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLEAR = 7'b0000010,
    ST_PUSH  = 7'b0000100,
    ST_ELEM  = 7'b0001000,
    ST_WBACK = 7'b0010000,
    ST_MID   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  // Operand selections for the shared adder.
  typedef enum logic [1:0] {
    ALU_ACC_PLUS_B = 2'd0,
    ALU_A_PLUS_B   = 2'd1,
    ALU_A_MINUS_B  = 2'd2,
    ALU_PASS_B     = 2'd3
  } alu_e;

  typedef struct packed {
    alu_e        sel;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

endpackage

FILE: src/rars_alu.sv
// Shared 32-bit add / subtract unit with a registered accumulator.
module rars_alu (
  input  logic               clk_i,
  input  logic               acc_clr_i,
  input  logic               acc_en_i,
  input  rars_pkg::alu_req_t req_i,
  output logic [31:0]        res_o,
  output logic [31:0]        acc_o
);
  logic [31:0] acc_q, acc_d;

  always_comb begin
    case (req_i.sel)
      rars_pkg::ALU_ACC_PLUS_B: res_o = acc_q + req_i.b;
      rars_pkg::ALU_A_PLUS_B:   res_o = req_i.a + req_i.b;
      rars_pkg::ALU_A_MINUS_B:  res_o = req_i.a - req_i.b;
      default:                  res_o = req_i.b;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (acc_clr_i) acc_d = '0;
    else if (acc_en_i) acc_d = res_o;
  end

  always_ff @(posedge clk_i) acc_q <= acc_d;

  assign acc_o = acc_q;
endmodule

FILE: src/range_add_range_sum_blocks.sv
// Top level of the range add / range sum store with per-block lazy adds.
//
//  channel | direction | words
//  s_axis  | in        | tdata: operation, range_low, range_high, value; one op per word
//  m_axis  | out       | tdata: range_sum; one word per sum operation
//
// The sequencer carries out one operation at a time; it walks the store with one shared
// adder, one element per cycle through the element memory. A write pushes the lazy add
// of its block down, stores the element and sums the block again. An add pushes down and
// sums again each end block and adds the value to the lazy word of each middle block; a
// sum walks each end segment, adds the block sum plus lazy word times block length of
// each middle block and then hands the total to the output. After reset a clearing pass
// zeroes the element store with s_axis_tready low. s_axis_tready is high only while idle;
// a finished sum word waits in the output register and holds the sequencer only when a
// further sum is ready before it has been taken.
`include "assert_macros.svh"
module range_add_range_sum_blocks #(
  parameter int NUM_ELEMENTS = 1024,
  parameter int BLOCK_SIZE   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] operation, [11:2] range_low, [21:12] range_high, [53:22] value, [55:54] zero
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] range_sum
  output logic [31:0] m_axis_tdata
);
  localparam int NB  = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int EW  = $clog2(NUM_ELEMENTS);
  localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
  localparam int XW  = (EW + 1 > 11) ? EW + 1 : 11;
  localparam int LAST_LEN = NUM_ELEMENTS - (NB - 1) * BLOCK_SIZE;
  // Reciprocal of the block size, exact for every index of XW bits.
  localparam int DSH  = XW + $clog2(BLOCK_SIZE);
  localparam int DMUL = ((1 << DSH) + BLOCK_SIZE - 1) / BLOCK_SIZE;

  // Element store: one read and one write port, read data registered.
  logic [31:0] mem [NUM_ELEMENTS];
  logic [31:0] rd_q;
  logic [EW-1:0] raddr, waddr;
  logic        we;
  logic [31:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Block words live in flip-flops: each is read at one address per cycle.
  logic [31:0] bsum_q [NB];
  logic [31:0] lazy_q [NB];
  logic [NB-1:0] bsum_we, lazy_we;
  logic [31:0] bsum_wd, lazy_wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        bsum_q[i] <= '0;
        lazy_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NB; i++) begin
        if (bsum_we[i]) bsum_q[i] <= bsum_wd;
        if (lazy_we[i]) lazy_q[i] <= lazy_wd;
      end
    end
  end

  rars_pkg::state_e state_q, state_d;
  rars_pkg::op_e    op_q;
  logic [XW-1:0] lo_q, hi_q;
  logic [31:0]   val_q;
  logic [BW-1:0] blk_q, blk_d;     // block being worked on
  logic [BW-1:0] stb_q, enb_q;     // first and last block of the range
  logic [XW-1:0] idx_q, idx_d;     // element walk index
  logic [XW-1:0] stop_q, stop_d;   // walk end, exclusive
  logic          rdv_q, rdv_d;     // rd_q holds element at idx_q-1
  logic [1:0]    phase_q, phase_d; // 0 first end block, 1 last end block
  logic [31:0]   res_q, res_d;
  logic          outv_q, outv_d;
  logic [XW-1:0] prev_q;

  // Inputs decoded.
  logic [1:0]    in_op;
  logic [XW-1:0] in_lo, in_hi, hi_cl;
  assign in_op = s_axis_tdata[1:0];
  assign in_lo = XW'(s_axis_tdata[11:2]);
  assign in_hi = XW'(s_axis_tdata[21:12]);
  assign hi_cl = (in_hi >= XW'(NUM_ELEMENTS)) ? XW'(NUM_ELEMENTS - 1) : in_hi;

  // Block of an element index, by multiplying with the reciprocal of the block size.
  function automatic logic [BW-1:0] blk_of(input logic [XW-1:0] e);
    logic [XW+DSH-1:0] p;
    p = (XW+DSH)'(e) * (XW+DSH)'(DMUL);
    return p[DSH +: BW];
  endfunction
  function automatic logic [XW-1:0] start_of(input logic [BW-1:0] b);
    return XW'(b) * XW'(BLOCK_SIZE);
  endfunction
  function automatic logic [XW-1:0] stop_of(input logic [BW-1:0] b);
    logic [XW:0] e;
    e = (XW+1)'(b) * (XW+1)'(BLOCK_SIZE) + (XW+1)'(BLOCK_SIZE);
    return (e > (XW+1)'(NUM_ELEMENTS)) ? XW'(NUM_ELEMENTS) : e[XW-1:0];
  endfunction
  function automatic logic [31:0] len_of(input logic [BW-1:0] b);
    return (32'(b) == 32'(NB - 1)) ? 32'(LAST_LEN) : 32'(BLOCK_SIZE);
  endfunction

  logic accept;
  assign s_axis_tready = (state_q == rars_pkg::ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  rars_pkg::alu_req_t req;
  logic [31:0] alu_res, acc;
  logic        acc_clr, acc_en;
  rars_alu u_alu (
    .clk_i(clk_i), .acc_clr_i(acc_clr), .acc_en_i(acc_en),
    .req_i(req), .res_o(alu_res), .acc_o(acc)
  );

  logic [31:0] cur_lazy;
  assign cur_lazy = lazy_q[blk_q];

  // Range of elements the current end block touches.
  logic [XW-1:0] seg_lo, seg_hi_x;
  always_comb begin
    if (phase_q == 2'd0) seg_lo = lo_q;
    else seg_lo = start_of(blk_q);
    if (phase_q == 2'd0 && stb_q != enb_q) seg_hi_x = stop_of(blk_q);
    else seg_hi_x = hi_q + XW'(1);
  end

  logic in_seg;
  assign in_seg = (prev_q >= seg_lo) && (prev_q < seg_hi_x);

  // Multiply lazy by block length in a dedicated registered product.
  logic [31:0] mid_prod_q;
  logic [BW-1:0] mid_blk_q;
  always_ff @(posedge clk_i) begin
    mid_prod_q <= lazy_q[blk_q] * len_of(blk_q);
    mid_blk_q  <= blk_q;
  end
  logic mid_pipe_q;

  always_comb begin
    state_d = state_q; blk_d = blk_q; idx_d = idx_q; stop_d = stop_q;
    rdv_d = 1'b0; phase_d = phase_q; res_d = res_q; outv_d = outv_q;
    we = 1'b0; waddr = idx_q[EW-1:0]; wdata = '0; raddr = idx_q[EW-1:0];
    bsum_we = '0; lazy_we = '0; bsum_wd = '0; lazy_wd = '0;
    acc_clr = 1'b0; acc_en = 1'b0;
    req = '{sel: rars_pkg::ALU_PASS_B, a: '0, b: '0};
    if (outv_q && m_axis_tready) outv_d = 1'b0;
    case (state_q)
      rars_pkg::ST_CLEAR: begin
        we = 1'b1; wdata = '0;
        idx_d = idx_q + XW'(1);
        if (idx_q == XW'(NUM_ELEMENTS - 1)) state_d = rars_pkg::ST_IDLE;
      end
      rars_pkg::ST_IDLE: begin
        if (accept) begin
          acc_clr = 1'b1; phase_d = 2'd0;
          blk_d = blk_of(in_lo);
          if (in_op == rars_pkg::OP_WRITE) begin
            if (in_lo < XW'(NUM_ELEMENTS)) begin
              idx_d = start_of(blk_of(in_lo)); stop_d = stop_of(blk_of(in_lo));
              state_d = rars_pkg::ST_PUSH;
            end
          end else if (in_op == rars_pkg::OP_ADD || in_op == rars_pkg::OP_SUM) begin
            if (in_lo < XW'(NUM_ELEMENTS) && in_lo <= hi_cl) begin
              idx_d = start_of(blk_of(in_lo)); stop_d = stop_of(blk_of(in_lo));
              state_d = (in_op == rars_pkg::OP_ADD) ? rars_pkg::ST_PUSH
                                                   : rars_pkg::ST_ELEM;
              if (in_op == rars_pkg::OP_SUM) begin
                idx_d = in_lo;
                stop_d = (blk_of(in_lo) == blk_of(hi_cl)) ? hi_cl + XW'(1)
                                                         : stop_of(blk_of(in_lo));
              end
            end else if (in_op == rars_pkg::OP_SUM) begin
              state_d = rars_pkg::ST_OUT;
            end
          end
        end
      end
      // Read each element of the block, add the lazy word and, for an add, the value
      // where the element lies in range; write the element back to the store.
      rars_pkg::ST_PUSH: begin
        if (rdv_q) begin
          req.sel = rars_pkg::ALU_A_PLUS_B; req.a = rd_q;
          req.b = cur_lazy + ((op_q == rars_pkg::OP_ADD && in_seg) ? val_q : 32'd0);
          we = 1'b1; waddr = prev_q[EW-1:0]; wdata = alu_res;
        end
        if (idx_q < stop_q) begin
          idx_d = idx_q + XW'(1); rdv_d = 1'b1;
        end else begin
          state_d = rars_pkg::ST_WBACK;
        end
      end
      // Sum pass over the freshly written block, also serves the sum walk.
      rars_pkg::ST_ELEM: begin
        if (rdv_q) begin
          req.sel = rars_pkg::ALU_ACC_PLUS_B;
          req.b = rd_q + ((op_q == rars_pkg::OP_SUM) ? cur_lazy : 32'd0);
          acc_en = 1'b1;
        end
        if (idx_q < stop_q) begin
          idx_d = idx_q + XW'(1); rdv_d = 1'b1;
        end else if (op_q == rars_pkg::OP_SUM) begin
          if (phase_q == 2'd0 && stb_q != enb_q) begin
            phase_d = 2'd1;
            if (enb_q - stb_q > BW'(1)) begin
              blk_d = stb_q + BW'(1); state_d = rars_pkg::ST_MID;
            end else begin
              blk_d = enb_q; idx_d = start_of(enb_q); stop_d = hi_q + XW'(1);
            end
          end else begin
            state_d = rars_pkg::ST_OUT;
          end
        end else begin
          // Add or write: the block sum is the fresh total including this element.
          bsum_we[blk_q] = 1'b1; bsum_wd = alu_res;
          lazy_we[blk_q] = 1'b1; lazy_wd = '0;
          acc_clr = 1'b1;
          if (op_q == rars_pkg::OP_ADD && phase_q == 2'd0 && stb_q != enb_q) begin
            phase_d = 2'd1;
            if (enb_q - stb_q > BW'(1)) begin
              blk_d = stb_q + BW'(1); state_d = rars_pkg::ST_MID;
            end else begin
              blk_d = enb_q; idx_d = start_of(enb_q); stop_d = stop_of(enb_q);
              state_d = rars_pkg::ST_PUSH;
            end
          end else begin
            state_d = rars_pkg::ST_IDLE;
          end
        end
      end
      rars_pkg::ST_WBACK: begin
        if (op_q == rars_pkg::OP_WRITE) begin
          // Block is pushed down; rewrite the element then resum the block.
          we = 1'b1; waddr = lo_q[EW-1:0]; wdata = val_q;
        end
        lazy_we[blk_q] = 1'b1; lazy_wd = '0;
        idx_d = start_of(blk_q); stop_d = stop_of(blk_q);
        state_d = rars_pkg::ST_ELEM;
      end
      // Middle blocks: lazy add for an add, block contribution for a sum.
      rars_pkg::ST_MID: begin
        if (op_q == rars_pkg::OP_ADD) begin
          req.sel = rars_pkg::ALU_A_PLUS_B; req.a = cur_lazy; req.b = val_q;
          lazy_we[blk_q] = 1'b1; lazy_wd = alu_res;
        end else if (mid_pipe_q) begin
          req.sel = rars_pkg::ALU_ACC_PLUS_B; req.b = bsum_q[mid_blk_q] + mid_prod_q;
          acc_en = 1'b1;
        end
        if (op_q == rars_pkg::OP_SUM && !mid_pipe_q) begin
          // wait for the registered product of this block
        end else if (blk_q + BW'(1) == enb_q) begin
          blk_d = enb_q; idx_d = start_of(enb_q);
          if (op_q == rars_pkg::OP_ADD) begin
            stop_d = stop_of(enb_q); state_d = rars_pkg::ST_PUSH;
          end else begin
            stop_d = hi_q + XW'(1); state_d = rars_pkg::ST_ELEM;
          end
        end else begin
          blk_d = blk_q + BW'(1);
        end
      end
      // The total moves into the output register once that is free.
      rars_pkg::ST_OUT: begin
        if (!outv_q || m_axis_tready) begin
          outv_d = 1'b1; res_d = acc; state_d = rars_pkg::ST_IDLE;
        end
      end
      default: state_d = rars_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rars_pkg::ST_CLEAR;
      idx_q <= '0; rdv_q <= 1'b0; outv_q <= 1'b0; mid_pipe_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; rdv_q <= rdv_d; outv_q <= outv_d;
      mid_pipe_q <= (state_q == rars_pkg::ST_MID) && !mid_pipe_q && (state_d == state_q)
                    && (blk_d == blk_q);
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d; stop_q <= stop_d; phase_q <= phase_d; res_q <= res_d;
    prev_q <= idx_q;
    if (state_q == rars_pkg::ST_IDLE && accept) begin
      op_q <= rars_pkg::op_e'(in_op); lo_q <= in_lo; hi_q <= hi_cl;
      val_q <= s_axis_tdata[53:22];
      stb_q <= blk_of(in_lo); enb_q <= blk_of(hi_cl);
    end
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = res_q;

  `ASSERT_IMPL(a_busy_not_ready, clk_i, rst_ni,
               state_q != rars_pkg::ST_IDLE, !s_axis_tready, "ready while busy")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
               m_axis_tvalid && $stable(m_axis_tdata), "result word dropped")
  `ASSERT_NEXT(a_sum_word_raised, clk_i, rst_ni,
               state_q == rars_pkg::ST_OUT && (!m_axis_tvalid || m_axis_tready),
               m_axis_tvalid, "sum word not raised")
endmodule
